// ===== hw/rtl/lfhs_pkg.sv =====
package lfhs_pkg;

	localparam int LED_COUNT_W = 9;
	localparam int BOUND_W     = 12;
	localparam int DIVIDEND_W  = 12;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic [1:0] CFG_COOLING_RATE = 2'd0;
	localparam logic [1:0] CFG_SPARK_CHANCE = 2'd1;
	localparam logic [1:0] CFG_LED_COUNT    = 2'd2;

	localparam logic [7:0]             COOLING_RESET = 8'd55;
	localparam logic [7:0]             CHANCE_RESET  = 8'd120;
	localparam logic [LED_COUNT_W-1:0] LEDS_RESET    = 9'd256;

	localparam logic [DIVIDEND_W-1:0] COOL_SCALE = 12'd10;
	localparam logic [BOUND_W-1:0]    BOUND_BIAS = 12'd2;
	localparam logic [BOUND_W-1:0]    BOUND_RESET = 12'd2;
	localparam int                    COOL_SHIFT = 8;

	localparam logic [19:0] DRIFT_RECIP = 20'd683;
	localparam int          DRIFT_SHIFT = 11;

	localparam logic [15:0] RAMP_SCALE   = 16'd191;
	localparam logic [15:0] RAMP_ROUND   = 16'd127;
	localparam logic [25:0] DIV255_RECIP = 26'd257;
	localparam logic [7:0]  RAMP_HI      = 8'h80;
	localparam logic [7:0]  RAMP_MID     = 8'h40;
	localparam logic [7:0]  FULL         = 8'd255;

	typedef struct packed {
		logic       kind;
		logic [7:0] cool_draw;
		logic [7:0] spark_draw;
		logic [2:0] spark_cell;
		logic [7:0] spark_heat;
	} item_t;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic frame_start;
		logic pixel_load;
		logic bound_load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_frame;
		logic pixel_ok;
		logic div_busy;
		logic out_free;
	} status_t;

	function automatic rgb_t heat_colour(input logic [7:0] t);
		logic [15:0] x;
		logic [25:0] p;
		logic [7:0]  t192;
		logic [7:0]  ramp;
		rgb_t        c;
		x    = 16'(t) * RAMP_SCALE + RAMP_ROUND;
		p    = (26'(x) + 26'd1) * DIV255_RECIP;
		t192 = p[23:16];
		ramp = {t192[5:0], 2'b00};
		if (t192 > RAMP_HI) begin
			c = '{red: FULL, green: FULL, blue: ramp};
		end else if (t192 > RAMP_MID) begin
			c = '{red: FULL, green: ramp, blue: 8'd0};
		end else begin
			c = '{red: ramp, green: 8'd0, blue: 8'd0};
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/lfhs_div.sv =====
module lfhs_div #(
	parameter int DW = 12,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int NW = $clog2(DW + 1);

	logic [NW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= NW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/lfhs_datapath.sv =====
module lfhs_datapath #(
	parameter int MAX_LEDS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lfhs_pkg::item_t  item,
	input  lfhs_pkg::cmd_t   cmd,
	output lfhs_pkg::status_t status,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_addr,
	input  logic [8:0]       cfg_wdata,
	output lfhs_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_stall
);

	import lfhs_pkg::*;

	localparam int CW = $clog2(MAX_LEDS + 1);
	localparam int AW = $clog2(MAX_LEDS);
	localparam int NW = (CW > LED_COUNT_W) ? CW : LED_COUNT_W;

	logic [7:0]             cooling_rate_q;
	logic [7:0]             spark_chance_q;
	logic [LED_COUNT_W-1:0] led_count_q;

	logic                   spark_armed_q;
	logic [2:0]             spark_target_q;
	logic [7:0]             spark_amount_q;
	logic [BOUND_W-1:0]     cool_bound_q;
	logic [CW-1:0]          counter_q;
	logic [CW-1:0]          fill_q;
	logic [7:0]             prev_q;
	logic [7:0]             prev2_q;
	logic                   res_valid_q;

	logic [CW-1:0]          k_s1;
	logic [BOUND_W-1:0]     cooldown_s1;
	logic [7:0]             drift_s1;
	logic [7:0]             rd_s1;
	logic                   rd_ok_s1;
	logic                   spark_hit_s1;

	logic [7:0]             res_heat_q;
	logic [7:0]             res_index_q;
	logic                   res_last_q;

	logic [7:0]             heat_mem [MAX_LEDS];

	logic [NW-1:0]          lc;
	logic [CW-1:0]          n;
	logic                   div_busy;
	logic [DIVIDEND_W-1:0]  quotient;
	logic [19:0]            cool_prod;
	logic [9:0]             drift_sum;
	logic [19:0]            drift_prod;
	logic [7:0]             h;
	logic [7:0]             cooled;
	logic [7:0]             base;
	logic [7:0]             heat;
	rgb_t                   rgb;

	always_comb begin
		lc = NW'(led_count_q);
		if (lc == '0) begin
			n = CW'(1);
		end else if (lc > NW'(MAX_LEDS)) begin
			n = CW'(MAX_LEDS);
		end else begin
			n = CW'(lc);
		end
	end

	lfhs_div #(
		.DW(DIVIDEND_W),
		.VW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.frame_start),
		.dividend(DIVIDEND_W'(cooling_rate_q) * COOL_SCALE),
		.divisor (n),
		.busy    (div_busy),
		.quotient(quotient)
	);

	assign cool_prod  = 20'(item.cool_draw) * 20'(cool_bound_q);
	assign drift_sum  = 10'(prev_q) + {1'b0, prev2_q, 1'b0};
	assign drift_prod = 20'(drift_sum) * DRIFT_RECIP;

	always_comb begin
		h      = rd_ok_s1 ? rd_s1 : 8'd0;
		cooled = (cooldown_s1 > BOUND_W'(h)) ? 8'd0 : (h - cooldown_s1[7:0]);
		base   = (k_s1 >= CW'(2)) ? drift_s1 : cooled;
		heat   = spark_hit_s1 ? (base + spark_amount_q) : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_rate_q <= COOLING_RESET;
			spark_chance_q <= CHANCE_RESET;
			led_count_q    <= LEDS_RESET;
			spark_armed_q  <= 1'b0;
			spark_target_q <= '0;
			spark_amount_q <= '0;
			cool_bound_q   <= BOUND_RESET;
			counter_q      <= '0;
			fill_q         <= '0;
			prev_q         <= '0;
			prev2_q        <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_addr)
					CFG_COOLING_RATE: cooling_rate_q <= cfg_wdata[7:0];
					CFG_SPARK_CHANCE: spark_chance_q <= cfg_wdata[7:0];
					CFG_LED_COUNT:    led_count_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.frame_start) begin
				spark_armed_q  <= item.spark_draw < spark_chance_q;
				spark_target_q <= item.spark_cell;
				spark_amount_q <= item.spark_heat;
				counter_q      <= '0;
			end
			if (cmd.bound_load) begin
				cool_bound_q <= quotient + BOUND_BIAS;
			end
			if (cmd.commit) begin
				prev2_q     <= prev_q;
				prev_q      <= cooled;
				counter_q   <= k_s1 + CW'(1);
				res_valid_q <= 1'b1;
				if (k_s1 == fill_q) begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pixel_load) begin
			k_s1         <= counter_q;
			cooldown_s1  <= BOUND_W'(cool_prod >> COOL_SHIFT);
			drift_s1     <= 8'(drift_prod >> DRIFT_SHIFT);
			rd_ok_s1     <= counter_q < fill_q;
			spark_hit_s1 <= spark_armed_q && (counter_q == CW'(spark_target_q));
		end
		if (cmd.commit) begin
			res_heat_q  <= heat;
			res_index_q <= 8'(k_s1);
			res_last_q  <= (k_s1 + CW'(1)) == n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pixel_load) begin
			rd_s1 <= heat_mem[counter_q[AW-1:0]];
		end
		if (cmd.commit) begin
			heat_mem[k_s1[AW-1:0]] <= heat;
		end
	end

	assign rgb = heat_colour(res_heat_q);

	assign result.pixel_index = res_index_q;
	assign result.red         = rgb.red;
	assign result.green       = rgb.green;
	assign result.blue        = rgb.blue;
	assign result.last_pixel  = res_last_q;
	assign result_valid       = res_valid_q;

	assign status.is_frame = item.kind == KIND_FRAME;
	assign status.pixel_ok = counter_q < n;
	assign status.div_busy = div_busy;
	assign status.out_free = !res_valid_q || !result_stall;

endmodule

// ===== hw/rtl/lfhs_ctrl.sv =====
module lfhs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lfhs_pkg::status_t status,
	output lfhs_pkg::cmd_t    cmd
);

	import lfhs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_CALC = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = state_q != ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && status.is_frame) begin
					cmd.frame_start = 1'b1;
					state_d         = ST_DIV;
				end else if (accept && status.pixel_ok) begin
					cmd.pixel_load = 1'b1;
					state_d        = ST_CALC;
				end
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					cmd.bound_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_CALC: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/led_fire_heat_simulator.sv =====
// Pixel item: the transfer reads the heat store; the read-modify-write commit waits
// for a free output, then writes the heat back and registers the result. No new item
// is taken before the commit. Frame start: the 12-step iterative divider sets the
// cooling bound. Pixels past the active LED count are dropped with no result.
// Reset clears control state and loads the register defaults; the heat store reads
// as zero through a fill count, so no clearing pass is needed.
module led_fire_heat_simulator #(
	parameter int MAX_LEDS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lfhs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lfhs_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_addr,
	input  logic [8:0]        cfg_wdata
);

	import lfhs_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	lfhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lfhs_datapath #(
		.MAX_LEDS(MAX_LEDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

// ===== hw/rtl/lfhs_checker.sv =====
module lfhs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input lfhs_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input lfhs_pkg::result_t result
);

	import lfhs_pkg::*;

	a_frame_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == KIND_FRAME) |=> item_stall)
		else $error("frame start transfer did not hold the input for the divider");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a commit cycle");

endmodule

bind led_fire_heat_simulator lfhs_checker u_lfhs_checker (.*);
